// ----- rtl/txcw_pkg.sv -----
package txcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int ADDR_W  = 11;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int OP_W    = 2;
    localparam int VALUE_W = ATTR_W + CHAR_W;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_PUT       = 2'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_PUT,
        KIND_NEWLINE,
        KIND_BACKSPACE,
        KIND_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] char_code;
    } cmd_t;

endpackage

// ----- rtl/txcw_front.sv -----
module txcw_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op [1:0], char_code [9:2], zero pad above
    input  logic [txcw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             queue_full,
    output logic                             push,
    output txcw_pkg::cmd_t                   push_cmd
);

    logic [txcw_pkg::OP_W-1:0]   op;
    logic [txcw_pkg::CHAR_W-1:0] char_code;

    assign op        = s_tdata[txcw_pkg::OP_W-1:0];
    assign char_code = s_tdata[txcw_pkg::OP_W +: txcw_pkg::CHAR_W];

    always_comb
    begin
        push_cmd.char_code = char_code;
        unique case (op)
            txcw_pkg::OP_PUT:
            begin
                if (char_code == txcw_pkg::NEWLINE_CHAR)
                    push_cmd.kind = txcw_pkg::KIND_NEWLINE;
                else
                    push_cmd.kind = txcw_pkg::KIND_PUT;
            end
            txcw_pkg::OP_BACKSPACE: push_cmd.kind = txcw_pkg::KIND_BACKSPACE;
            txcw_pkg::OP_CLEAR:     push_cmd.kind = txcw_pkg::KIND_CLEAR;
            default:                push_cmd.kind = txcw_pkg::KIND_NOP;
        endcase
    end

    assign s_tready = !queue_full;
    // unused op codes are taken and dropped here
    assign push = s_tvalid && s_tready && (push_cmd.kind != txcw_pkg::KIND_NOP);

endmodule

// ----- rtl/txcw_queue.sv -----
module txcw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  txcw_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output txcw_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (txcw_pkg::QUEUE_DEPTH > 1) ? $clog2(txcw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(txcw_pkg::QUEUE_DEPTH + 1);

    txcw_pkg::cmd_t   entry_reg [txcw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(txcw_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(txcw_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/txcw_back.sv -----
module txcw_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [txcw_pkg::ATTR_W-1:0]       cfg_data,
    input  logic                              head_valid,
    input  txcw_pkg::cmd_t                    head_cmd,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [txcw_pkg::ADDR_W-1:0]       out_addr,
    output logic [txcw_pkg::VALUE_W-1:0]      out_value,
    output logic                              out_clear,
    output logic [txcw_pkg::ROW_W-1:0]        out_row,
    output logic [txcw_pkg::COL_W-1:0]        out_col
);

    localparam int ROW_W  = txcw_pkg::ROW_W;
    localparam int COL_W  = txcw_pkg::COL_W;
    localparam int ADDR_W = txcw_pkg::ADDR_W;

    logic [txcw_pkg::ATTR_W-1:0]  attr_reg;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]            addr_reg;
    logic [txcw_pkg::VALUE_W-1:0] value_reg;
    logic                         clear_reg;
    logic [ROW_W-1:0]             row_after_reg;
    logic [COL_W-1:0]             col_after_reg;

    logic                         emit;
    logic [ROW_W-1:0]             addr_row;
    logic [COL_W-1:0]             addr_col;
    logic [ROW_W-1:0]             row_wrap;
    logic [ADDR_W-1:0]            cell_addr;
    logic [txcw_pkg::CHAR_W-1:0]  cell_char;
    logic                         is_clear;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    assign row_wrap = (row_reg == ROW_W'(txcw_pkg::SCREEN_HEIGHT - 1)) ?
                      '0 : row_reg + ROW_W'(1);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        emit      = 1'b0;
        addr_row  = row_reg;
        addr_col  = col_reg;
        cell_char = txcw_pkg::BLANK_CHAR;
        is_clear  = 1'b0;
        unique case (head_cmd.kind)
            txcw_pkg::KIND_PUT:
            begin
                emit      = 1'b1;
                cell_char = head_cmd.char_code;
                if (col_reg == COL_W'(txcw_pkg::SCREEN_WIDTH - 1))
                begin
                    col_next = '0;
                    row_next = row_wrap;
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            txcw_pkg::KIND_NEWLINE:
            begin
                col_next = '0;
                row_next = row_wrap;
            end
            txcw_pkg::KIND_BACKSPACE:
            begin
                // blank lands on the new cursor cell; nothing at origin
                if (col_reg != '0)
                begin
                    emit     = 1'b1;
                    col_next = col_reg - COL_W'(1);
                end
                else if (row_reg != '0)
                begin
                    emit     = 1'b1;
                    row_next = row_reg - ROW_W'(1);
                    col_next = COL_W'(txcw_pkg::SCREEN_WIDTH - 1);
                end
                addr_row = row_next;
                addr_col = col_next;
            end
            txcw_pkg::KIND_CLEAR:
            begin
                emit     = 1'b1;
                is_clear = 1'b1;
                row_next = '0;
                col_next = '0;
                addr_row = '0;
                addr_col = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign cell_addr = ADDR_W'(ADDR_W'(addr_row) * ADDR_W'(txcw_pkg::SCREEN_WIDTH))
                       + ADDR_W'(addr_col);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= txcw_pkg::ATTR_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                attr_reg <= cfg_data;
            if (pop)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            addr_reg      <= cell_addr;
            value_reg     <= {attr_reg, cell_char};
            clear_reg     <= is_clear;
            row_after_reg <= row_next;
            col_after_reg <= col_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = addr_reg;
    assign out_value = value_reg;
    assign out_clear = clear_reg;
    assign out_row   = row_after_reg;
    assign out_col   = col_after_reg;

endmodule

// ----- rtl/text_console_cell_writer.sv -----
// Channel   Dir  Words                     Handshake
// s_*       in   console op, char byte     s_tvalid / s_tready
// m_*       out  cell write or clear req   m_tvalid / m_tready
// cfg_*     in   text attribute byte       cfg_valid / cfg_ready
//
// One op per cycle sustained while m_tready is high; an accepted op goes
// into the command queue and its word is registered once the cursor unit
// takes the head (when its output register is empty or being drained). A
// low m_tready fills the two-entry command queue, then s_tready drops until
// a word leaves. Newline, backspace at origin and unused codes produce no
// word. Reset: cursor at origin, attribute 0x07. cfg_ready is always high.
module text_console_cell_writer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op [1:0], char_code [9:2], zero [15:10]
    input  logic [txcw_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cell_address [10:0], cell_value [26:11], cursor_row_after [31:27],
    // cursor_col_after [38:32], zero [39]
    output logic [txcw_pkg::M_TDATA_W-1:0]   m_tdata,
    // clear_screen [0]
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [txcw_pkg::ATTR_W-1:0]      cfg_data
);

    logic                           queue_full;
    logic                           push;
    txcw_pkg::cmd_t                 push_cmd;
    logic                           pop;
    logic                           head_valid;
    txcw_pkg::cmd_t                 head_cmd;
    logic [txcw_pkg::ADDR_W-1:0]    out_addr;
    logic [txcw_pkg::VALUE_W-1:0]   out_value;
    logic                           out_clear;
    logic [txcw_pkg::ROW_W-1:0]     out_row;
    logic [txcw_pkg::COL_W-1:0]     out_col;

    txcw_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    txcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    txcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (out_addr),
        .out_value  (out_value),
        .out_clear  (out_clear),
        .out_row    (out_row),
        .out_col    (out_col)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, out_col, out_row, out_value, out_addr};
    assign m_tuser   = out_clear;

endmodule

// ----- rtl/txcw_checker.sv -----
module txcw_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [txcw_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]                       m_tuser
);

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed under stall");

    // clear request always homes the cursor at cell 0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tdata[10:0] == 11'd0 && m_tdata[31:27] == 5'd0 && m_tdata[38:32] == 7'd0)
    else $error("clear word not at origin");

    // cursor and address stay on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            m_tdata[31:27] < 5'(txcw_pkg::SCREEN_HEIGHT) &&
            m_tdata[38:32] < 7'(txcw_pkg::SCREEN_WIDTH) &&
            m_tdata[10:0] < 11'(txcw_pkg::SCREEN_WIDTH * txcw_pkg::SCREEN_HEIGHT))
    else $error("cursor or cell address off screen");

    // a clear carries a blank character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[18:11] == txcw_pkg::BLANK_CHAR)
    else $error("clear word without blank character");

endmodule

bind text_console_cell_writer txcw_checker u_txcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/txcw_cell_checker.sv -----
`timescale 1ns / 1ps

module txcw_cell_checker
    import txcw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]             m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [ATTR_W-1:0]      cfg_data,
    output int                     mismatches,
    output int                     pending
);

    localparam int VALUE_LSB = ADDR_W;
    localparam int ROW_LSB   = VALUE_LSB + VALUE_W;
    localparam int COL_LSB   = ROW_LSB + ROW_W;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [VALUE_W-1:0] value;
        logic               clear_req;
        logic [ROW_W-1:0]   row_after;
        logic [COL_W-1:0]   col_after;
    } cell_word_t;

    cell_word_t        writes_due[$];
    cell_word_t        due_word;
    cell_word_t        seen_word;
    logic [ROW_W-1:0]  row_now;
    logic [COL_W-1:0]  col_now;
    logic [ATTR_W-1:0] attr_now;
    int                words_seen;

    function automatic logic [ADDR_W-1:0] cursor_index();
        return ADDR_W'(int'(row_now) * SCREEN_WIDTH + int'(col_now));
    endfunction

    function automatic void next_row();
        if (int'(row_now) + 1 >= SCREEN_HEIGHT)
            row_now = '0;
        else
            row_now = row_now + 1'b1;
    endfunction

    function automatic cell_word_t make_word(input logic [ADDR_W-1:0] addr,
                                             input logic [CHAR_W-1:0] ch,
                                             input logic clr);
        cell_word_t w;
        w.address   = addr;
        w.value     = {attr_now, ch};
        w.clear_req = clr;
        w.row_after = row_now;
        w.col_after = col_now;
        return w;
    endfunction

    // Moves the cursor for one console op; returns 1 when a word is due.
    function automatic bit apply_console_op(input logic [OP_W-1:0] op,
                                            input logic [CHAR_W-1:0] ch,
                                            output cell_word_t w);
        logic [ADDR_W-1:0] addr;
        w = '0;
        case (op)
            OP_PUT:
            begin
                if (ch == NEWLINE_CHAR)
                begin
                    col_now = '0;
                    next_row();
                    return 1'b0;
                end
                addr = cursor_index();
                if (int'(col_now) + 1 >= SCREEN_WIDTH)
                begin
                    col_now = '0;
                    next_row();
                end
                else
                    col_now = col_now + 1'b1;
                w = make_word(addr, ch, 1'b0);
                return 1'b1;
            end
            OP_BACKSPACE:
            begin
                if (col_now == '0)
                begin
                    if (row_now == '0)
                        return 1'b0;
                    row_now = row_now - 1'b1;
                    col_now = COL_W'(SCREEN_WIDTH - 1);
                end
                else
                    col_now = col_now - 1'b1;
                w = make_word(cursor_index(), BLANK_CHAR, 1'b0);
                return 1'b1;
            end
            OP_CLEAR:
            begin
                row_now = '0;
                col_now = '0;
                w = make_word('0, BLANK_CHAR, 1'b1);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writes_due.delete();
            row_now    = '0;
            col_now    = '0;
            attr_now   = ATTR_RESET;
            mismatches = 0;
            pending    = 0;
            words_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_word.address   = m_tdata[VALUE_LSB-1:0];
                seen_word.value     = m_tdata[ROW_LSB-1:VALUE_LSB];
                seen_word.clear_req = m_tuser[0];
                seen_word.row_after = m_tdata[COL_LSB-1:ROW_LSB];
                seen_word.col_after = m_tdata[COL_LSB+COL_W-1:COL_LSB];
                if (writes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d unexpected: addr %0d value %h clr %0b row %0d col %0d",
                                 words_seen, seen_word.address, seen_word.value,
                                 seen_word.clear_req, seen_word.row_after,
                                 seen_word.col_after);
                end
                else
                begin
                    due_word = writes_due.pop_front();
                    if (due_word.address != seen_word.address
                        || due_word.value != seen_word.value
                        || due_word.clear_req != seen_word.clear_req
                        || due_word.row_after != seen_word.row_after
                        || due_word.col_after != seen_word.col_after)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("word %0d expected: addr %0d value %h clr %0b row %0d col %0d",
                                     words_seen, due_word.address, due_word.value,
                                     due_word.clear_req, due_word.row_after,
                                     due_word.col_after);
                            $display("word %0d actual:   addr %0d value %h clr %0b row %0d col %0d",
                                     words_seen, seen_word.address, seen_word.value,
                                     seen_word.clear_req, seen_word.row_after,
                                     seen_word.col_after);
                        end
                    end
                end
                words_seen++;
            end
            if (cfg_valid && cfg_ready)
                attr_now = cfg_data;
            if (s_tvalid && s_tready)
                if (apply_console_op(s_tdata[OP_W-1:0], s_tdata[OP_W+CHAR_W-1:OP_W], due_word))
                    writes_due.push_back(due_word);
            pending = writes_due.size();
        end
    end

endmodule

// ----- bench/text_console_cell_writer_tb.sv -----
`timescale 1ns / 1ps

module text_console_cell_writer_tb;
    import txcw_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 80;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [ATTR_W-1:0]    cfg_data  = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;
    wire [0:0]            m_tuser;
    wire                  cfg_ready;
    int                   mismatches;
    int                   pending;

    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_request = 1'b0;

    always #5 clk = ~clk;

    text_console_cell_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    txcw_cell_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
        int gap;
        bit ready_seen;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OP_W - CHAR_W){1'b0}}, ch, op};
        // ready is stable by the falling edge, so sample it there
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
    endtask

    task automatic wait_all_written();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        // words with no result may still be in the queue
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] attr);
        bit ready_seen;
        cfg_valid <= 1'b1;
        cfg_data  <= attr;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_mix(input int count, input int put_w, input int nl_w,
                           input int bs_w, input int clr_w);
        int r;
        logic [CHAR_W-1:0] ch;
        repeat (count)
        begin
            r  = $urandom_range(0, put_w + nl_w + bs_w + clr_w + 1);
            ch = CHAR_W'($urandom_range(0, 255));
            if (r < put_w)
                send_word(OP_PUT, ch);
            else if (r < put_w + nl_w)
                send_word(OP_PUT, NEWLINE_CHAR);
            else if (r < put_w + nl_w + bs_w)
                send_word(OP_BACKSPACE, ch);
            else if (r < put_w + nl_w + bs_w + clr_w)
                send_word(OP_CLEAR, ch);
            else
                send_word(OP_UNUSED, ch);
        end
    endtask

    // walk to the last row, fill it so the cursor wraps to the origin,
    // while the receiver holds off and the block backs up
    task automatic fill_to_origin();
        logic [CHAR_W-1:0] ch;
        tx_steady = 1'b1;
        send_word(OP_CLEAR, CHAR_W'($urandom_range(0, 255)));
        repeat (SCREEN_HEIGHT - 1) send_word(OP_PUT, NEWLINE_CHAR);
        hold_request = 1'b1;
        repeat (SCREEN_WIDTH)
        begin
            ch = CHAR_W'($urandom_range(0, 255));
            if (ch == NEWLINE_CHAR)
                ch = BLANK_CHAR;
            send_word(OP_PUT, ch);
        end
        send_word(OP_BACKSPACE, CHAR_W'($urandom_range(0, 255)));
        tx_steady = 1'b0;
    endtask

    initial
    begin
        int run_len;
        int gap;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_tready <= 1'b1;
            run_len = $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
            gap = rx_steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("text_console_cell_writer_tb failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset attribute; corner cases of the cursor
        send_word(OP_BACKSPACE, 8'hFF);     // at origin: no word
        send_word(OP_PUT, 8'h00);
        send_word(OP_PUT, 8'hFF);
        send_word(OP_PUT, NEWLINE_CHAR);
        send_word(OP_BACKSPACE, 8'h00);     // back across the row edge
        send_word(OP_PUT, 8'h41);           // column wrap into next row
        send_word(OP_UNUSED, 8'hFF);
        send_word(OP_UNUSED, 8'h00);
        send_word(OP_BACKSPACE, 8'h5A);
        send_word(OP_CLEAR, 8'hA5);
        send_word(OP_BACKSPACE, 8'h5A);     // origin again after clear
        send_word(OP_PUT, 8'h80);
        send_word(OP_PUT, 8'h7F);
        send_word(OP_PUT, BLANK_CHAR);
        send_word(OP_BACKSPACE, 8'h00);
        send_word(OP_BACKSPACE, 8'hFF);
        send_word(OP_BACKSPACE, 8'h0A);
        send_word(OP_BACKSPACE, 8'h01);     // at origin: no word
        send_word(OP_PUT, NEWLINE_CHAR);
        send_word(OP_PUT, NEWLINE_CHAR);
        send_word(OP_BACKSPACE, 8'h00);
        send_word(OP_CLEAR, 8'h00);

        wait_all_written();
        write_attr(8'hFF);
        run_mix(100, 60, 12, 15, 2);

        wait_all_written();
        write_attr(8'h00);
        fill_to_origin();

        wait_all_written();
        write_attr(ATTR_W'($urandom_range(1, 254)));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_mix(120, 70, 10, 8, 1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_mix(120, 35, 10, 40, 1);

        wait_all_written();
        if (mismatches == 0 && pending == 0)
            $display("text_console_cell_writer_tb passed");
        else
            $display("text_console_cell_writer_tb failed");
        $finish;
    end

endmodule
